[hw/rtl/assert_macros.svh]
// Assertion macros shared by the spin-update RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ISG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies an outcome in the next cycle.
`define ISG_ASSERT_NEXT(lbl, cond, nxt_cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt_cond)) \
    else $error(msg);

`endif

[hw/rtl/isg_pkg.sv]
// Shared constants, codes and types for the Ising spin-update block.
// No dependencies; imported by the sequencer, the decision logic and the top level.
`timescale 1ns / 1ps

package isg_pkg;

  // Default lattice side (sites per row and per column).
  localparam int unsigned SIDE_DEF = 16;

  // Field widths.
  localparam int unsigned SITE_W  = 4;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned RND_W   = 16;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned DE_W    = 5;
  localparam int unsigned MAG_W   = 10;
  localparam int unsigned UPCNT_W = 3;

  // Stream widths.
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = ACT_W;
  localparam int unsigned OUT_TDATA_W = 24;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_THR_DE4 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_DE8 = 1'd1;

  localparam logic [THR_W-1:0] THR_DE4_RST = 16'd11246;
  localparam logic [THR_W-1:0] THR_DE8_RST = 16'd1929;

  // Action codes; the unused code behaves as a read.
  localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  // Operands of the flip decision.
  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic               old_spin;
    logic [UPCNT_W-1:0] up_cnt;
    logic               wval;
    logic [RND_W-1:0]   rnd;
    logic [THR_W-1:0]   thr_de4;
    logic [THR_W-1:0]   thr_de8;
  } dec_req_t;

  // Outcome of the flip decision.
  typedef struct packed {
    logic                   flip;
    logic                   spin_after;
    logic signed [DE_W-1:0] de;
  } dec_rsp_t;

endpackage

[hw/rtl/isg_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; holds the spin lattice.
`timescale 1ns / 1ps

module isg_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/isg_decide.sv]
// Energy change and flip decision for one site from its spin and its up-neighbor count.
// Depends on isg_pkg for the action codes and the request/response types.
`timescale 1ns / 1ps

module isg_decide (
  input  isg_pkg::dec_req_t req,
  output isg_pkg::dec_rsp_t rsp
);

  import isg_pkg::*;

  logic signed [DE_W:0]   nb_term;
  logic signed [DE_W-1:0] de_up;
  logic signed [DE_W-1:0] de_upd;
  logic                   flip_upd;

  // For an up spin dE = 4*ups - 8; a down spin negates it.
  always_comb begin
    nb_term  = $signed({1'b0, req.up_cnt, 2'b00}) - (DE_W + 1)'(8);
    de_up    = nb_term[DE_W-1:0];
    de_upd   = req.old_spin ? de_up : -de_up;
    flip_upd = 1'b0;
    if (de_upd[DE_W-1] || (de_upd == '0)) begin
      flip_upd = 1'b1;
    end else if (de_upd == DE_W'(4)) begin
      flip_upd = (req.rnd <= req.thr_de4);
    end else begin
      flip_upd = (req.rnd <= req.thr_de8);
    end
  end

  // Select by action; reads and the unused code leave the spin alone.
  always_comb begin
    rsp.flip = 1'b0;
    rsp.de   = '0;
    case (req.action)
      ACT_UPDATE: begin
        rsp.flip = flip_upd;
        rsp.de   = de_upd;
      end
      ACT_WRITE: begin
        rsp.flip = (req.wval != req.old_spin);
      end
      default: begin
        rsp.flip = 1'b0;
      end
    endcase
    rsp.spin_after = req.old_spin ^ rsp.flip;
  end

endmodule

[hw/rtl/isg_seq.sv]
// Sequencer: clears the lattice after reset, reads a site (and for an update its neighbors) from the RAM,
// writes the new spin back and holds the result. Depends on isg_pkg, isg_decide and assert_macros.svh.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module isg_seq #(
  parameter int unsigned SIDE = isg_pkg::SIDE_DEF,
  localparam int unsigned AW = $clog2(SIDE * SIDE)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [isg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [isg_pkg::IN_TUSER_W-1:0]  in_tuser,
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [isg_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Acceptance thresholds.
  input  logic [isg_pkg::THR_W-1:0]       thr_de4,
  input  logic [isg_pkg::THR_W-1:0]       thr_de8,
  // Lattice RAM.
  output logic                            ram_we,
  output logic [AW-1:0]                   ram_waddr,
  output logic                            ram_wdata,
  output logic [AW-1:0]                   ram_raddr,
  input  logic                            ram_rdata
);

  import isg_pkg::*;

  localparam int unsigned IW = $clog2(SIDE);
  localparam int unsigned NSITES = SIDE * SIDE;
  localparam logic [AW-1:0]    CLR_LAST = AW'(NSITES - 1);
  localparam logic [IW-1:0]    IDX_MAX  = IW'(SIDE - 1);
  localparam logic [MAG_W-1:0] MAG_RST  = MAG_W'(NSITES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // Read steps: the site itself, then its four torus neighbors.
  localparam logic [2:0] STEP_CTR   = 3'd0;
  localparam logic [2:0] STEP_DOWN  = 3'd1;
  localparam logic [2:0] STEP_UP    = 3'd2;
  localparam logic [2:0] STEP_RIGHT = 3'd3;
  localparam logic [2:0] STEP_LEFT  = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [AW-1:0]           clr_cnt_r;
  logic [IW-1:0]           row_r, col_r;
  logic [ACT_W-1:0]        act_r;
  logic [RND_W-1:0]        rnd_r;
  logic                    wval_r;
  logic [2:0]              step_r;
  logic                    rtag_vld_r;
  logic [2:0]              rtag_r;
  logic                    center_r;
  logic [UPCNT_W-1:0]      up_cnt_r;
  logic [MAG_W-1:0]        sum_r, sum_nxt;
  logic                    out_valid_r;
  logic [OUT_TDATA_W-1:0]  out_data_r;

  logic                    in_acc;
  logic                    out_load;
  logic [2:0]              last_step;
  logic [IW-1:0]           rd_row, rd_col;
  logic [AW-1:0]           ctr_addr;
  dec_req_t                dec_req;
  dec_rsp_t                dec_rsp;

  // Site index modulo SIDE; three subtractions cover the 4-bit index when SIDE is at least 4.
  function automatic logic [IW-1:0] wrap_site(input logic [SITE_W-1:0] v);
    logic [8:0] t;
    t = {5'b0, v};
    for (int k = 0; k < 3; k++) begin
      if (t >= 9'(SIDE)) begin
        t = t - 9'(SIDE);
      end
    end
    return t[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] inc_wrap(input logic [IW-1:0] v);
    return (v == IDX_MAX) ? '0 : v + IW'(1);
  endfunction

  function automatic logic [IW-1:0] dec_wrap(input logic [IW-1:0] v);
    return (v == '0) ? IDX_MAX : v - IW'(1);
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign last_step = (act_r == ACT_UPDATE) ? STEP_LEFT : STEP_CTR;

  // Read address for the current step.
  always_comb begin
    rd_row = row_r;
    rd_col = col_r;
    case (step_r)
      STEP_DOWN:  rd_row = inc_wrap(row_r);
      STEP_UP:    rd_row = dec_wrap(row_r);
      STEP_RIGHT: rd_col = inc_wrap(col_r);
      STEP_LEFT:  rd_col = dec_wrap(col_r);
      default:    rd_row = row_r;
    endcase
  end

  assign ram_raddr = AW'(rd_row) * AW'(SIDE) + AW'(rd_col);
  assign ctr_addr  = AW'(row_r) * AW'(SIDE) + AW'(col_r);

  // Flip decision.
  always_comb begin
    dec_req.action   = act_r;
    dec_req.old_spin = center_r;
    dec_req.up_cnt   = up_cnt_r;
    dec_req.wval     = wval_r;
    dec_req.rnd      = rnd_r;
    dec_req.thr_de4  = thr_de4;
    dec_req.thr_de8  = thr_de8;
  end

  isg_decide u_decide (
    .req (dec_req),
    .rsp (dec_rsp)
  );

  // Write port: all-up sweep after reset, then the write-back of a flipped spin.
  always_comb begin
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = 1'b1;
    end else begin
      ram_we    = out_load && dec_rsp.flip;
      ram_waddr = ctr_addr;
      ram_wdata = dec_rsp.spin_after;
    end
  end

  // Running magnetization after this request.
  always_comb begin
    sum_nxt = sum_r;
    if (dec_rsp.flip) begin
      sum_nxt = dec_rsp.spin_after ? sum_r + MAG_W'(2) : sum_r - MAG_W'(2);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == CLR_LAST) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc) state_nxt = S_READ;
      S_READ:  if (step_r == last_step) state_nxt = S_WAIT;
      S_WAIT:  state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      step_r      <= STEP_CTR;
      rtag_vld_r  <= 1'b0;
      up_cnt_r    <= '0;
      sum_r       <= MAG_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rtag_vld_r <= (state_r == S_READ);
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (in_acc) begin
        step_r   <= STEP_CTR;
        up_cnt_r <= '0;
      end else begin
        if ((state_r == S_READ) && (step_r != last_step)) begin
          step_r <= step_r + 3'd1;
        end
        if (rtag_vld_r && (rtag_r != STEP_CTR) && ram_rdata) begin
          up_cnt_r <= up_cnt_r + UPCNT_W'(1);
        end
      end
      if (out_load) begin
        sum_r       <= sum_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request fields, read data and the result register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_r  <= wrap_site(in_tdata[3:0]);
      col_r  <= wrap_site(in_tdata[7:4]);
      rnd_r  <= in_tdata[23:8];
      wval_r <= in_tdata[24];
      act_r  <= in_tuser;
    end
    rtag_r <= step_r;
    if (rtag_vld_r && (rtag_r == STEP_CTR)) begin
      center_r <= ram_rdata;
    end
    if (out_load) begin
      out_data_r <= {7'b0, sum_nxt, dec_rsp.de, dec_rsp.flip, dec_rsp.spin_after};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ISG_ASSERT_NEXT(a_sum_only_on_result, !out_load, $stable(sum_r),
    "magnetization changed without a result")
  `ISG_ASSERT(a_up_cnt_range, up_cnt_r <= UPCNT_W'(4),
    "more than four up neighbors counted")
  `ISG_ASSERT(a_read_keeps_spin,
    out_load && (act_r != ACT_UPDATE) && (act_r != ACT_WRITE) |-> !dec_rsp.flip,
    "read request flipped a spin")
  `ISG_ASSERT(a_de_values,
    out_load |-> (dec_rsp.de == -DE_W'(8)) || (dec_rsp.de == -DE_W'(4)) ||
      (dec_rsp.de == '0) || (dec_rsp.de == DE_W'(4)) || (dec_rsp.de == DE_W'(8)),
    "energy change outside the five lattice values")

endmodule

[hw/rtl/ising_metropolis_spin_update_top.sv]
// An update makes five serial reads of the lattice RAM (the site, then its four neighbors), waits
// for the registered read data, then decides and writes back; a read or write reads the site only.
// A new request is taken only once the last result is in the output register, so a stalled result
// channel holds off requests. Reset (rst_n low, synchronous) restores thresholds and magnetization,
// then a clearing pass over all SIDE*SIDE sites (256 by default) sets every spin up; no request is
// taken until it ends. Configuration writes are taken whenever rst_n is high, even while clearing.
`timescale 1ns / 1ps

module ising_metropolis_spin_update_top #(
  parameter int unsigned SIDE = isg_pkg::SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] site_row, [7:4] site_col, [23:8] random_word, [24] spin_value, [31:25] zero
  input  logic [isg_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] action
  input  logic [isg_pkg::IN_TUSER_W-1:0]  in_tuser,
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] spin_after, [1] flipped, [6:2] energy_change, [16:7] magnetization, [23:17] zero
  output logic [isg_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [isg_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [isg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import isg_pkg::*;

  localparam int unsigned AW = $clog2(SIDE * SIDE);

  logic [THR_W-1:0] thr_de4_r;
  logic [THR_W-1:0] thr_de8_r;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic             ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic             ram_rdata;

  // Acceptance thresholds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_de4_r <= THR_DE4_RST;
      thr_de8_r <= THR_DE8_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_THR_DE4: thr_de4_r <= cfg_wdata[THR_W-1:0];
        CFG_THR_DE8: thr_de8_r <= cfg_wdata[THR_W-1:0];
        default:     thr_de4_r <= thr_de4_r;
      endcase
    end
  end

  // Sequencer and decision logic.
  isg_seq #(
    .SIDE (SIDE)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .thr_de4    (thr_de4_r),
    .thr_de8    (thr_de8_r),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // Spin lattice, one bit per site.
  isg_ram #(
    .WIDTH (1),
    .DEPTH (SIDE * SIDE)
  ) u_lattice (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
